// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the deadline completion table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge out of reset.
`define DCT_ASSERT(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("dct assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define DCT_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dct implication failed");

// The consequent must hold in the cycle after the antecedent.
`define DCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dct next-cycle check failed");

`endif

// ===== hw/rtl/dct_pkg.sv =====
// Types, codes and constants of the deadline completion table.
`default_nettype none

package dct_pkg;

  // Default number of slots and the most completions one drain may fire.
  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned MaxFired     = 16;

  // Input mode codes.
  localparam logic [1:0] ModeSchedule = 2'd0;
  localparam logic [1:0] ModeDrain    = 2'd1;
  localparam logic [1:0] ModeClear    = 2'd2;
  localparam logic [1:0] ModeUnused   = 2'd3;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_SCHED_REPLY = 2'd0,
    KIND_FIRED       = 2'd1,
    KIND_EMPTY       = 2'd2,
    KIND_CLEAR       = 2'd3
  } kind_e;

  // Schedule outcomes.
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  // Commands passed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_REJECT   = 2'd1,
    OP_DRAIN    = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] now;
    logic [63:0] deadline;
    logic [15:0] callback;
    logic [15:0] tag;
    logic [7:0]  status;
  } cmd_t;

  // One stored slot in the table RAM.
  typedef struct packed {
    logic [63:0] deadline;
    logic [15:0] callback;
    logic [15:0] tag;
    logic [7:0]  status;
  } entry_t;

  // One result beat.
  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [3:0]  slot;
    logic [15:0] callback;
    logic [15:0] tag;
    logic [7:0]  fstatus;
    logic [4:0]  pending;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dct_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module dct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dct_front.sv =====
// Front end: accepts input beats, classifies them and queues commands.
`default_nettype none

module dct_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire logic [1:0]    mode_i,
  input  wire logic [63:0]   now_us_i,
  input  wire logic [31:0]   delay_us_i,
  input  wire logic [15:0]   callback_id_i,
  input  wire logic [15:0]   context_tag_i,
  input  wire logic [7:0]    carried_status_i,
  output      logic          cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output      dct_pkg::cmd_t cmd_o
);
  import dct_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  cmd_t            fifo_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;
  cmd_t            cmd_new;
  logic            accept, push, pop;

  assign in_ready_o  = (cnt_q != (PtrW+1)'(Depth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  assign accept = in_valid_i && in_ready_o;
  // The unused mode is dropped here and never reaches the back end.
  assign push   = accept && (mode_i != ModeUnused);
  assign pop    = cmd_valid_o && cmd_ready_i;

  // Classify the beat and compute the deadline, which wraps modulo 2^64.
  always_comb begin
    cmd_new.now      = now_us_i;
    cmd_new.deadline = now_us_i + {32'd0, delay_us_i};
    cmd_new.callback = callback_id_i;
    cmd_new.tag      = context_tag_i;
    cmd_new.status   = carried_status_i;
    case (mode_i)
      ModeSchedule: cmd_new.op = (callback_id_i == 16'd0) ? OP_REJECT : OP_SCHEDULE;
      ModeDrain:    cmd_new.op = OP_DRAIN;
      ModeClear:    cmd_new.op = OP_CLEAR;
      default:      cmd_new.op = OP_CLEAR;
    endcase
  end

  // Command queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dct_back.sv =====
// Back end: sequencer that scans the slot table and produces result beats.
`default_nettype none

module dct_back #(
  parameter int unsigned Slots = dct_pkg::SlotsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cmd_valid_i,
  output      logic                         cmd_ready_o,
  input  wire dct_pkg::cmd_t                cmd_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      dct_pkg::res_t                res_o,
  output      logic                         busy_o,
  output      logic [$clog2(Slots+1)-1:0]   used_count_o
);
  import dct_pkg::*;

  localparam int unsigned IW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CW = $clog2(Slots + 1);
  localparam int unsigned SW = (IW > 4) ? IW : 4;
  localparam int unsigned PW = (CW > 5) ? CW : 5;
  localparam int unsigned FW = $clog2(MaxFired + 1);
  localparam int unsigned EW = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_EMIT,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [Slots-1:0] used_q, used_d;
  logic [CW-1:0]    count_q, count_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [FW-1:0]    fired_q, fired_d;
  cmd_t             cmd_q, cmd_d;
  res_t             res_q, res_d;
  res_t             held_q, held_d;
  logic             held_v_q, held_v_d;
  res_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic            ram_we, ram_re;
  logic [EW-1:0]   ram_rdata;
  entry_t          wr_entry, rd_entry;
  logic            last_idx, out_free, expired, fired_max;
  logic [SW-1:0]   slot_ext;
  logic [PW-1:0]   count_ext, count_inc_ext, count_dec_ext;

  assign cmd_ready_o  = (state_q == ST_IDLE);
  assign busy_o       = (state_q != ST_IDLE);
  assign used_count_o = count_q;
  assign out_valid_o  = out_valid_q;
  assign res_o        = out_q;

  assign last_idx  = (idx_q == IW'(Slots - 1));
  assign out_free  = !out_valid_q || out_ready_i;
  assign fired_max = (fired_q == FW'(MaxFired));
  assign rd_entry  = entry_t'(ram_rdata);
  assign expired   = (rd_entry.deadline <= cmd_q.now);

  // Extend the index and counts to at least the result field widths.
  assign slot_ext      = SW'(idx_q);
  assign count_ext     = PW'(count_q);
  assign count_inc_ext = PW'(count_q + CW'(1));
  assign count_dec_ext = PW'(count_q - CW'(1));

  // Table RAM access: a write when a schedule finds a free slot,
  // a read for each used slot during a drain.
  assign ram_we = (state_q == ST_FIND) && !used_q[idx_q];
  assign ram_re = (state_q == ST_READ) && !fired_max && used_q[idx_q];

  always_comb begin
    wr_entry.deadline = cmd_q.deadline;
    wr_entry.callback = cmd_q.callback;
    wr_entry.tag      = cmd_q.tag;
    wr_entry.status   = cmd_q.status;
  end

  dct_ram #(
    .Width (EW),
    .Depth (Slots)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Next state of the sequencer, the slot bookkeeping and the output register.
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    count_d     = count_q;
    idx_d       = idx_q;
    fired_d     = fired_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    held_d      = held_q;
    held_v_d    = held_v_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d      = cmd_i;
          idx_d      = '0;
          fired_d    = '0;
          held_v_d   = 1'b0;
          res_d      = '0;
          res_d.last = 1'b1;
          case (cmd_i.op)
            OP_SCHEDULE: begin
              state_d = ST_FIND;
            end
            OP_REJECT: begin
              res_d.kind    = KIND_SCHED_REPLY;
              res_d.status  = STATUS_INVALID;
              res_d.pending = count_ext[4:0];
              state_d       = ST_EMIT;
            end
            OP_DRAIN: begin
              state_d = ST_READ;
            end
            OP_CLEAR: begin
              used_d     = '0;
              count_d    = '0;
              res_d.kind = KIND_CLEAR;
              state_d    = ST_EMIT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // Look for the lowest free slot, one slot per cycle.
      ST_FIND: begin
        if (!used_q[idx_q]) begin
          used_d[idx_q] = 1'b1;
          count_d       = count_q + CW'(1);
          res_d.kind    = KIND_SCHED_REPLY;
          res_d.status  = STATUS_OK;
          res_d.slot    = slot_ext[3:0];
          res_d.pending = count_inc_ext[4:0];
          state_d       = ST_EMIT;
        end else if (last_idx) begin
          res_d.kind    = KIND_SCHED_REPLY;
          res_d.status  = STATUS_FULL;
          res_d.pending = count_ext[4:0];
          state_d       = ST_EMIT;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      // Drain: issue a read for a used slot, skip a free one, stop at the fire limit.
      ST_READ: begin
        if (fired_max) begin
          state_d = ST_DONE;
        end else if (used_q[idx_q]) begin
          state_d = ST_CHECK;
        end else if (last_idx) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      // Compare the deadline. An expired slot is freed and held back one
      // step, so that the final completion can carry the last flag.
      ST_CHECK: begin
        if (!expired || !held_v_q || out_free) begin
          if (expired) begin
            if (held_v_q) begin
              out_d       = held_q;
              out_valid_d = 1'b1;
            end
            held_d.kind     = KIND_FIRED;
            held_d.status   = STATUS_OK;
            held_d.slot     = slot_ext[3:0];
            held_d.callback = rd_entry.callback;
            held_d.tag      = rd_entry.tag;
            held_d.fstatus  = rd_entry.status;
            held_d.pending  = count_dec_ext[4:0];
            held_d.last     = 1'b0;
            held_v_d        = 1'b1;
            used_d[idx_q]   = 1'b0;
            count_d         = count_q - CW'(1);
            fired_d         = fired_q + FW'(1);
          end
          if (last_idx) begin
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = ST_READ;
          end
        end
      end

      // Close the drain with the held completion or an empty marker.
      ST_DONE: begin
        if (out_free) begin
          if (held_v_q) begin
            out_d      = held_q;
            out_d.last = 1'b1;
          end else begin
            out_d         = '0;
            out_d.kind    = KIND_EMPTY;
            out_d.pending = count_ext[4:0];
            out_d.last    = 1'b1;
          end
          out_valid_d = 1'b1;
          held_v_d    = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer state, slot bookkeeping and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      fired_q     <= '0;
      cmd_q       <= '0;
      res_q       <= '0;
      held_q      <= '0;
      held_v_q    <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      fired_q     <= fired_d;
      cmd_q       <= cmd_d;
      res_q       <= res_d;
      held_q      <= held_d;
      held_v_q    <= held_v_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/deadline_completion_table.sv =====
// Top level of the deadline completion table.
`default_nettype none
`include "assert_macros.svh"

// A table of Slots pending completions, each with a 64-bit deadline, a callback
// handle, a context tag and a status byte. Mode 0 schedules a completion at
// now_us + delay_us (wrapping modulo 2^64) in the lowest free slot, mode 1
// drains every used slot whose deadline is at or before now_us in slot order,
// mode 2 clears the table, and mode 3 is dropped without a result. Input beats
// enter a two-entry command queue, so the host can hand over up to two items
// while the back end is busy. All work is done by one back-end sequencer that
// visits the slots in turn through the single read port of the slot RAM and
// takes a new command only when idle. A schedule scans for a free slot and
// then emits its reply; a drain reads and checks each used slot, skips each
// free one and closes with a final beat; reject and clear go straight to their
// reply. Every result beat waits in an output register, and the sequencer
// holds whenever it has a further beat to hand on while that register is still
// occupied. Slot contents need no clearing after reset: per-slot used bits are
// cleared at once by reset.
module deadline_completion_table #(
  parameter int unsigned Slots = dct_pkg::SlotsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [63:0] now_us_i,
  input  wire logic [31:0] delay_us_i,
  input  wire logic [15:0] callback_id_i,
  input  wire logic [15:0] context_tag_i,
  input  wire logic [7:0]  carried_status_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [1:0]  kind_o,
  output      logic [1:0]  status_o,
  output      logic [3:0]  slot_index_o,
  output      logic [15:0] fired_callback_o,
  output      logic [15:0] fired_tag_o,
  output      logic [7:0]  fired_status_o,
  output      logic [4:0]  pending_count_o,
  output      logic        last_o
);
  import dct_pkg::*;

  localparam int unsigned CW = $clog2(Slots + 1);

  logic          cmd_valid, cmd_ready, back_busy;
  cmd_t          cmd;
  res_t          res;
  logic [CW-1:0] used_count;

  dct_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .now_us_i         (now_us_i),
    .delay_us_i       (delay_us_i),
    .callback_id_i    (callback_id_i),
    .context_tag_i    (context_tag_i),
    .carried_status_i (carried_status_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_ready_i      (cmd_ready),
    .cmd_o            (cmd)
  );

  dct_back #(
    .Slots (Slots)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res),
    .busy_o       (back_busy),
    .used_count_o (used_count)
  );

  // Unpack the result beat onto the output ports.
  assign kind_o           = res.kind;
  assign status_o         = res.status;
  assign slot_index_o     = res.slot;
  assign fired_callback_o = res.callback;
  assign fired_tag_o      = res.tag;
  assign fired_status_o   = res.fstatus;
  assign pending_count_o  = res.pending;
  assign last_o           = res.last;

  // Only a completion can be followed by more beats of the same item.
  `DCT_ASSERT_IMPLY(a_single_beat_last, out_valid_o && (kind_o != KIND_FIRED), last_o)
  // A fired completion never carries the empty callback handle.
  `DCT_ASSERT_IMPLY(a_fired_has_cb, out_valid_o && (kind_o == KIND_FIRED),
                    fired_callback_o != 16'd0)
  // Taking a command always starts the sequencer.
  `DCT_ASSERT_NEXT(a_cmd_starts_back, cmd_valid && cmd_ready, back_busy)
  // The pending count never exceeds the table size.
  `DCT_ASSERT(a_count_bound, used_count <= CW'(Slots))

endmodule

`default_nettype wire

// ===== tb/sv/tb_deadline_completion_table.sv =====
// Self-checking testbench for the deadline completion table.
`timescale 1ns / 100ps

module tb_deadline_completion_table;
  import dct_pkg::*;

  localparam int NumSlots   = 16;
  localparam int DirRows    = 25;
  localparam int RandItems  = 85;
  localparam int TailCycles = 60;
  localparam int MaxReports = 10;

  // One input item as the host presents it.
  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] now;
    logic [31:0] delta;
    logic [15:0] cb;
    logic [15:0] tag;
    logic [7:0]  stat;
  } item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = '0;
  logic [63:0] now_us_i = '0;
  logic [31:0] delay_us_i = '0;
  logic [15:0] callback_id_i = '0;
  logic [15:0] context_tag_i = '0;
  logic [7:0]  carried_status_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [1:0]  status_o;
  logic [3:0]  slot_index_o;
  logic [15:0] fired_callback_o;
  logic [15:0] fired_tag_o;
  logic [7:0]  fired_status_o;
  logic [4:0]  pending_count_o;
  logic        last_o;

  deadline_completion_table #(.Slots(NumSlots)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .now_us_i        (now_us_i),
    .delay_us_i      (delay_us_i),
    .callback_id_i   (callback_id_i),
    .context_tag_i   (context_tag_i),
    .carried_status_i(carried_status_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .status_o        (status_o),
    .slot_index_o    (slot_index_o),
    .fired_callback_o(fired_callback_o),
    .fired_tag_o     (fired_tag_o),
    .fired_status_o  (fired_status_o),
    .pending_count_o (pending_count_o),
    .last_o          (last_o)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the slot table, updated at every accepted input beat.
  logic        shadow_busy [NumSlots];
  logic [63:0] shadow_due  [NumSlots];
  logic [15:0] shadow_cb   [NumSlots];
  logic [15:0] shadow_tag  [NumSlots];
  logic [7:0]  shadow_stat [NumSlots];
  int          shadow_count;

  res_t  shadow_out[$];    // results of the latest item
  res_t  awaited_results[$];
  int    err_count;
  int    sent_count;
  int    sink_count;
  bit    send_calm;
  bit    sink_calm;
  logic [63:0] base_time;

  // Directed stimulus with optional hand-written expectations.
  item_t dir_items [DirRows];
  bit    dir_has_typed [DirRows];
  res_t  dir_typed [DirRows];

  // Empties the shadow table, as reset and a clear do.
  function automatic void shadow_wipe();
    for (int i = 0; i < NumSlots; i++) begin
      shadow_busy[i] = 1'b0;
      shadow_due[i]  = '0;
      shadow_cb[i]   = '0;
      shadow_tag[i]  = '0;
      shadow_stat[i] = '0;
    end
    shadow_count = 0;
  endfunction

  // Applies one item to the shadow table and collects the results it causes.
  function automatic void step_shadow(item_t it);
    res_t r;
    int   hit;
    shadow_out.delete();
    r = '0;
    r.kind = KIND_SCHED_REPLY;
    r.status = STATUS_OK;
    r.last = 1'b1;
    case (it.mode)
      ModeSchedule: begin
        hit = -1;
        if (it.cb == '0) begin
          r.status = STATUS_INVALID;
        end else begin
          for (int i = 0; i < NumSlots; i++) begin
            if (hit < 0 && !shadow_busy[i]) hit = i;
          end
          if (hit < 0) begin
            r.status = STATUS_FULL;
          end else begin
            shadow_busy[hit] = 1'b1;
            shadow_due[hit]  = it.now + 64'(it.delta);
            shadow_cb[hit]   = it.cb;
            shadow_tag[hit]  = it.tag;
            shadow_stat[hit] = it.stat;
            shadow_count++;
            r.slot = 4'(hit);
          end
        end
        r.pending = 5'(shadow_count);
        shadow_out.push_back(r);
      end
      ModeDrain: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (shadow_busy[i] && shadow_due[i] <= it.now && shadow_out.size() < MaxFired) begin
            shadow_busy[i] = 1'b0;
            if (shadow_count > 0) shadow_count--;
            r = '0;
            r.kind = KIND_FIRED;
            r.status = STATUS_OK;
            r.slot = 4'(i);
            r.callback = shadow_cb[i];
            r.tag = shadow_tag[i];
            r.fstatus = shadow_stat[i];
            r.pending = 5'(shadow_count);
            r.last = 1'b0;
            shadow_out.push_back(r);
          end
        end
        if (shadow_out.size() == 0) begin
          r.kind = KIND_EMPTY;
          r.pending = 5'(shadow_count);
          shadow_out.push_back(r);
        end else begin
          shadow_out[shadow_out.size() - 1].last = 1'b1;
        end
      end
      ModeClear: begin
        shadow_wipe();
        r.kind = KIND_CLEAR;
        shadow_out.push_back(r);
      end
      default: begin
        // The unused mode leaves the table alone and answers nothing.
      end
    endcase
  endfunction

  // A single final result, written out by hand.
  function automatic res_t typed_beat(kind_e k, status_e s, logic [3:0] slot,
                                      logic [15:0] cb, logic [15:0] tag,
                                      logic [7:0] fst, logic [4:0] pend);
    res_t r;
    r.kind = k;
    r.status = s;
    r.slot = slot;
    r.callback = cb;
    r.tag = tag;
    r.fstatus = fst;
    r.pending = pend;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic string show(res_t r);
    return $sformatf("kind %0d status %0d slot %0d cb %h tag %h fst %h pend %0d last %0d",
                     r.kind, r.status, r.slot, r.callback, r.tag, r.fstatus,
                     r.pending, r.last);
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.mode  = 2'($urandom);
    it.now   = {$urandom, $urandom};
    it.delta = $urandom;
    it.cb    = 16'($urandom);
    it.tag   = 16'($urandom);
    it.stat  = 8'($urandom);
    return it;
  endfunction

  // A schedule around the running time base, now and then with a zero callback or a large delay.
  function automatic item_t sched_item();
    item_t it;
    it = noise_item();
    it.mode  = ModeSchedule;
    it.now   = base_time;
    it.delta = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200);
    it.cb    = ($urandom_range(0, 24) == 0) ? 16'h0 : 16'($urandom_range(1, 65535));
    return it;
  endfunction

  // Mostly schedules and drains near the time base, with some clears and noise.
  function automatic item_t random_item();
    item_t it;
    int    pick;
    base_time = base_time + 64'($urandom_range(0, 40));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it = sched_item();
    end else begin
      it = noise_item();
      if (pick < 80) begin
        it.mode = ModeDrain;
        if (pick >= 5 + 70) it.now = base_time + 64'($urandom_range(0, 250));
        else it.now = base_time + 64'($urandom_range(0, 250));
        if ($urandom_range(0, 19) == 0) it.now = {$urandom, $urandom};
      end else if (pick < 86) begin
        it.mode = ModeClear;
      end else if (pick < 92) begin
        it.mode = ModeUnused;
      end
    end
    return it;
  endfunction

  function automatic void build_directed();
    item_t ones;
    item_t zeros;
    ones  = '1;
    zeros = '0;
    for (int i = 0; i < DirRows; i++) begin
      dir_has_typed[i] = 1'b0;
      dir_typed[i] = '0;
    end
    // Drain of an empty table after reset.
    dir_items[0] = zeros;
    dir_items[0].mode = ModeDrain;
    dir_has_typed[0] = 1'b1;
    dir_typed[0] = typed_beat(KIND_EMPTY, STATUS_OK, 4'd0, '0, '0, '0, 5'd0);
    // Zero callback is rejected, every other field at its maximum.
    dir_items[1] = ones;
    dir_items[1].mode = ModeSchedule;
    dir_items[1].cb = '0;
    dir_has_typed[1] = 1'b1;
    dir_typed[1] = typed_beat(KIND_SCHED_REPLY, STATUS_INVALID, 4'd0, '0, '0, '0, 5'd0);
    // The unused mode is dropped silently.
    dir_items[2] = ones;
    // Largest now and delay: the deadline wraps around.
    dir_items[3] = ones;
    dir_items[3].mode = ModeSchedule;
    dir_has_typed[3] = 1'b1;
    dir_typed[3] = typed_beat(KIND_SCHED_REPLY, STATUS_OK, 4'd0, '0, '0, '0, 5'd1);
    // Smallest fields with the smallest valid callback.
    dir_items[4] = zeros;
    dir_items[4].mode = ModeSchedule;
    dir_items[4].cb = 16'd1;
    dir_has_typed[4] = 1'b1;
    dir_typed[4] = typed_beat(KIND_SCHED_REPLY, STATUS_OK, 4'd1, '0, '0, '0, 5'd2);
    // Fill the rest of the table with random content.
    for (int i = 5; i <= 19; i++) begin
      dir_items[i] = noise_item();
      dir_items[i].mode = ModeSchedule;
      dir_items[i].cb = 16'($urandom_range(1, 65535));
    end
    // One more schedule finds the table full.
    dir_has_typed[19] = 1'b1;
    dir_typed[19] = typed_beat(KIND_SCHED_REPLY, STATUS_FULL, 4'd0, '0, '0, '0, 5'd16);
    // A drain at the end of time fires all sixteen slots.
    dir_items[20] = noise_item();
    dir_items[20].mode = ModeDrain;
    dir_items[20].now = '1;
    // Deadline 105 is not yet due at 104 and fires exactly at 105.
    dir_items[21] = zeros;
    dir_items[21].mode = ModeSchedule;
    dir_items[21].now = 64'd100;
    dir_items[21].delta = 32'd5;
    dir_items[21].cb = 16'h1234;
    dir_items[21].tag = 16'hABCD;
    dir_items[21].stat = 8'h5A;
    dir_has_typed[21] = 1'b1;
    dir_typed[21] = typed_beat(KIND_SCHED_REPLY, STATUS_OK, 4'd0, '0, '0, '0, 5'd1);
    dir_items[22] = zeros;
    dir_items[22].mode = ModeDrain;
    dir_items[22].now = 64'd104;
    dir_has_typed[22] = 1'b1;
    dir_typed[22] = typed_beat(KIND_EMPTY, STATUS_OK, 4'd0, '0, '0, '0, 5'd1);
    dir_items[23] = zeros;
    dir_items[23].mode = ModeDrain;
    dir_items[23].now = 64'd105;
    dir_has_typed[23] = 1'b1;
    dir_typed[23] = typed_beat(KIND_FIRED, STATUS_OK, 4'd0, 16'h1234, 16'hABCD, 8'h5A, 5'd0);
    dir_items[24] = noise_item();
    dir_items[24].mode = ModeClear;
    dir_has_typed[24] = 1'b1;
    dir_typed[24] = typed_beat(KIND_CLEAR, STATUS_OK, 4'd0, '0, '0, '0, 5'd0);
  endfunction

  // Presents one input beat after a random gap and records what it should cause.
  task automatic offer_item(item_t it, bit has_typed, res_t typed);
    int gap;
    if (sent_count % 16 == 0) send_calm = ($urandom_range(0, 2) == 0);
    gap = send_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    mode_i           <= it.mode;
    now_us_i         <= it.now;
    delay_us_i       <= it.delta;
    callback_id_i    <= it.cb;
    context_tag_i    <= it.tag;
    carried_status_i <= it.stat;
    do @(posedge clk_i); while (!in_ready_o);
    step_shadow(it);
    if (has_typed) begin
      awaited_results.push_back(typed);
    end else begin
      foreach (shadow_out[i]) awaited_results.push_back(shadow_out[i]);
    end
    sent_count++;
  endtask

  // Holds the sender off until every awaited result has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // Compares one output beat with the oldest awaited result.
  function automatic void check_result();
    res_t got;
    res_t want;
    got.kind = kind_e'(kind_o);
    got.status = status_e'(status_o);
    got.slot = slot_index_o;
    got.callback = fired_callback_o;
    got.tag = fired_tag_o;
    got.fstatus = fired_status_o;
    got.pending = pending_count_o;
    got.last = last_o;
    if (awaited_results.size() == 0) begin
      if (err_count < MaxReports) $display("unexpected result beat: %s", show(got));
      err_count++;
    end else begin
      want = awaited_results.pop_front();
      if (got !== want) begin
        if (err_count < MaxReports) begin
          $display("result mismatch\n  expected %s\n  actual   %s", show(want), show(got));
        end
        err_count++;
      end
    end
  endfunction

  // Output side: accepts result beats with random stalls.
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      if (sink_count % 16 == 0) sink_calm = ($urandom_range(0, 2) == 0);
      stall = sink_calm ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_result();
      sink_count++;
    end
  end

  // Main sequence: reset, directed rows, random items, then the verdict.
  initial begin
    item_t it;
    int    done_items;
    int    burst_left;
    err_count = 0;
    sent_count = 0;
    sink_count = 0;
    burst_left = 0;
    shadow_wipe();
    build_directed();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirRows; i++) begin
      offer_item(dir_items[i], dir_has_typed[i], dir_typed[i]);
    end
    wait_drained();

    // Start the time base at zero, near the wrap point, or anywhere.
    case ($urandom_range(0, 2))
      0: base_time = '0;
      1: base_time = 64'hFFFF_FFFF_FFFF_FE00;
      default: base_time = {$urandom, $urandom};
    endcase

    done_items = 0;
    while (done_items < RandItems) begin
      if (done_items == RandItems / 2) wait_drained();
      // Bursts of schedules push the table toward full.
      if (burst_left == 0 && $urandom_range(0, 19) == 0) burst_left = $urandom_range(8, 20);
      if (burst_left > 0) begin
        it = sched_item();
        burst_left--;
      end else begin
        it = random_item();
      end
      offer_item(it, 1'b0, '0);
      if (it.mode != ModeUnused) done_items++;
    end
    in_valid_i <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[deadline_completion_table] OK");
    end else begin
      $display("[deadline_completion_table] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #1000000;
    $display("[deadline_completion_table] ERROR");
    $finish;
  end

endmodule
